FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and size constants of the text console writer
// no dependencies; imported by every module of the block except tcw_ram

package tcw_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;

  localparam int CELL_W     = 16;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int COLOR_W    = 8;
  localparam int CHAR_W     = 8;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd2;

  localparam logic [COL_W-1:0]   RESET_COLS  = 7'd80;
  localparam logic [ROW_W-1:0]   RESET_ROWS  = 5'd25;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_COLOR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // screen size in use and attribute, after clamping
  typedef struct packed {
    logic [ROW_W-1:0]   rows;
    logic [COL_W-1:0]   cols;
    logic [COLOR_W-1:0] color;
  } geom_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } result_t;

endpackage

FILE: sv/tcw_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcw_out_stage.sv
`timescale 1ns / 1ps
// output register of the result channel, decouples the sequencer from the receiver
// depends on tcw_pkg

module tcw_out_stage import tcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    slot_free_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

FILE: sv/tcw_ctrl.sv
`timescale 1ns / 1ps
// sequencer: cursor, operation decode, scroll / clear / init sweeps over the screen ram
// depends on tcw_pkg; drives the ports of a tcw_ram instance

module tcw_ctrl import tcw_pkg::*; #(
  parameter int MaxCols = MAX_COLS_DEF,
  parameter int MaxRows = MAX_ROWS_DEF,
  localparam int Cells = MaxRows * MaxCols,
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_W-1:0]  target_row_i,
  input  logic [COL_W-1:0]  target_col_i,
  input  geom_t             geom_i,
  input  logic              slot_free_i,
  output logic              load_o,
  output result_t           result_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic [CELL_W-1:0] mem_wdata_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  function automatic logic [AddrW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return AddrW'(int'(r) * MaxCols + int'(c));
  endfunction

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [ROW_W-1:0]  scan_row_q, scan_row_d;
  logic [COL_W-1:0]  scan_col_q, scan_col_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic              mv_pend_q, mv_pend_d;
  logic [AddrW-1:0]  mv_addr_q, mv_addr_d;

  logic              accept;
  logic [ROW_W-1:0]  last_row, eff_row, tgt_row, bs_row;
  logic [COL_W-1:0]  last_col, eff_col, tgt_col, bs_col;
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [CELL_W-1:0] blank;
  logic              new_line;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    last_row = geom_i.rows - ROW_W'(1);
    last_col = geom_i.cols - COL_W'(1);
    // cursor pulled back inside a shrunk screen
    eff_row  = (cur_row_q >= geom_i.rows) ? last_row : cur_row_q;
    eff_col  = (cur_col_q >= geom_i.cols) ? last_col : cur_col_q;
    tgt_row  = (target_row_i < geom_i.rows) ? target_row_i : last_row;
    tgt_col  = (target_col_i < geom_i.cols) ? target_col_i : last_col;
    row_inc  = {1'b0, eff_row} + (ROW_W+1)'(1);
    col_inc  = {1'b0, eff_col} + (COL_W+1)'(1);
    // backspace at column 0 goes to the last column of the row above (the top row stays)
    bs_row   = (eff_col == '0 && eff_row != '0) ? eff_row - ROW_W'(1) : eff_row;
    bs_col   = (eff_col == '0) ? last_col : eff_col - COL_W'(1);
    blank    = {geom_i.color, CH_SPACE};
  end

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    cell_d      = cell_q;
    scan_row_d  = scan_row_q;
    scan_col_d  = scan_col_q;
    sweep_d     = sweep_q;
    mv_pend_d   = 1'b0;
    mv_addr_d   = mv_addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = cell_addr(scan_row_q, scan_col_q);
    load_o      = 1'b0;
    new_line    = 1'b0;

    // second half of a scroll move: data read last cycle goes one row up
    if (mv_pend_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = mv_addr_q;
      mem_wdata_o = mem_rdata_i;
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = RESET_CELL;
        if (sweep_q == AddrW'(Cells - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_DONE;
          cell_d    = '0;
          cur_row_d = eff_row;
          cur_col_d = eff_col;
          unique case (op_e'(opcode_i))
            OP_PUT: begin
              unique case (char_code_i)
                CH_NUL: begin
                end
                CH_BS: begin
                  cur_row_d   = bs_row;
                  cur_col_d   = bs_col;
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cell_addr(bs_row, bs_col);
                  mem_wdata_o = blank;
                end
                CH_CR: begin
                  cur_col_d = '0;
                end
                CH_LF: begin
                  new_line = 1'b1;
                end
                default: begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cell_addr(eff_row, eff_col);
                  mem_wdata_o = {geom_i.color, char_code_i};
                  if (col_inc >= {1'b0, geom_i.cols}) begin
                    new_line = 1'b1;
                  end else begin
                    cur_col_d = col_inc[COL_W-1:0];
                  end
                end
              endcase
              if (new_line) begin
                cur_col_d = '0;
                if (row_inc >= {1'b0, geom_i.rows}) begin
                  cur_row_d  = last_row;
                  scan_col_d = '0;
                  scan_row_d = ROW_W'(1);
                  state_d    = (geom_i.rows == ROW_W'(1)) ? ST_BLANK : ST_SCROLL;
                end else begin
                  cur_row_d = row_inc[ROW_W-1:0];
                end
              end
            end
            OP_MOVE: begin
              cur_row_d = tgt_row;
              cur_col_d = tgt_col;
            end
            OP_CLEAR: begin
              cur_row_d = '0;
              cur_col_d = '0;
              sweep_d   = '0;
              state_d   = ST_CLEAR;
            end
            OP_READ: begin
              mem_raddr_o = cell_addr(tgt_row, tgt_col);
              state_d     = ST_READ;
            end
          endcase
        end
      end

      ST_READ: begin
        cell_d  = mem_rdata_i;
        state_d = ST_DONE;
      end

      ST_SCROLL: begin
        mv_pend_d = 1'b1;
        mv_addr_d = cell_addr(scan_row_q - ROW_W'(1), scan_col_q);
        if (scan_col_q == last_col) begin
          scan_col_d = '0;
          if (scan_row_q == last_row) begin
            state_d = ST_BLANK;
          end else begin
            scan_row_d = scan_row_q + ROW_W'(1);
          end
        end else begin
          scan_col_d = scan_col_q + COL_W'(1);
        end
      end

      ST_BLANK: begin
        // waits while the last move still holds the write port
        if (!mv_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cell_addr(last_row, scan_col_q);
          mem_wdata_o = blank;
          if (scan_col_q == last_col) begin
            state_d = ST_DONE;
          end else begin
            scan_col_d = scan_col_q + COL_W'(1);
          end
        end
      end

      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = blank;
        if (sweep_q == AddrW'(Cells - 1)) begin
          state_d = ST_DONE;
        end else begin
          sweep_d = sweep_q + AddrW'(1);
        end
      end

      ST_DONE: begin
        if (slot_free_i) begin
          load_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  assign result_o = '{cell_val: cell_q, row: cur_row_q, col: cur_col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cur_row_q <= '0;
      cur_col_q <= '0;
      sweep_q   <= '0;
      mv_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      sweep_q   <= sweep_d;
      mv_pend_q <= mv_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    scan_row_q <= scan_row_d;
    scan_col_q <= scan_col_d;
    mv_addr_q  <= mv_addr_d;
  end

endmodule

FILE: sv/text_console_writer_unit.sv
`timescale 1ns / 1ps
// text console writer: screen of 16-bit cells (char low byte, color high byte)
// and a cursor. Input channel (in_valid_i / in_stall_o) carries one operation:
// put character, move cursor, clear screen or read cell. Every operation gives
// exactly one result (cell_value_o, cursor_row_o, cursor_col_o) on the output
// channel (out_valid_o / out_stall_i); a transaction happens when valid is high
// and stall is low. Items are handled one at a time by the sequencer around a
// single screen ram (one write, one registered read port):
//   put char without scroll, move cursor: done on accept, then the result is handed on
//   read cell: an extra state waits for the registered ram read
//   line feed or wrap past the last row: (rows-1)*cols moves, then cols blank
//   writes
//   clear screen: all MaxRows*MaxCols cells, one cell written per cycle
// Results sit in an output register, so the next item is taken while a result
// waits; a stalled receiver only holds up the block once a second result is done.
// After reset a clearing pass writes the blank cell 0x0720 to all
// MaxRows*MaxCols entries with in_stall_o high.
// Configuration writes (cfg_ready_o always high) take effect at once and are
// expected only while the block is idle.

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int MaxCols = MAX_COLS_DEF,
  parameter int MaxRows = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [ROW_W-1:0]      target_row_i,
  input  logic [COL_W-1:0]      target_col_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CELL_W-1:0]     cell_value_o,
  output logic [ROW_W-1:0]      cursor_row_o,
  output logic [COL_W-1:0]      cursor_col_o
);

  localparam int Cells = MaxRows * MaxCols;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  logic [COL_W-1:0]   cols_q;
  logic [ROW_W-1:0]   rows_q;
  logic [COLOR_W-1:0] color_q;
  geom_t              geom;

  logic              slot_free, load;
  result_t           result, out_result;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= RESET_COLS;
      rows_q  <= RESET_ROWS;
      color_q <= RESET_COLOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_COLS:  cols_q  <= cfg_data_i[COL_W-1:0];
        CFG_ROWS:  rows_q  <= cfg_data_i[ROW_W-1:0];
        CFG_COLOR: color_q <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // size in use: clamped to 1..max
  always_comb begin
    geom.color = color_q;
    if (cols_q == '0) begin
      geom.cols = COL_W'(1);
    end else if (32'(cols_q) > MaxCols) begin
      geom.cols = COL_W'(MaxCols);
    end else begin
      geom.cols = cols_q;
    end
    if (rows_q == '0) begin
      geom.rows = ROW_W'(1);
    end else if (32'(rows_q) > MaxRows) begin
      geom.rows = ROW_W'(MaxRows);
    end else begin
      geom.rows = rows_q;
    end
  end

  tcw_ctrl #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .target_row_i(target_row_i),
    .target_col_i(target_col_i),
    .geom_i      (geom),
    .slot_free_i (slot_free),
    .load_o      (load),
    .result_o    (result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_ram #(
    .Width(CELL_W),
    .Depth(Cells)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  tcw_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .result_i   (result),
    .out_stall_i(out_stall_i),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .result_o   (out_result)
  );

  assign cell_value_o = out_result.cell_val;
  assign cursor_row_o = out_result.row;
  assign cursor_col_o = out_result.col;

endmodule

FILE: sv/tcw_checker.sv
`timescale 1ns / 1ps
// port-level checker of the text console writer and its bind to the top level
// depends on tcw_pkg and text_console_writer_unit

module tcw_checker import tcw_pkg::*; #(
  parameter int MaxCols = MAX_COLS_DEF,
  parameter int MaxRows = MAX_ROWS_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ROW_W-1:0] cursor_row_o,
  input logic [COL_W-1:0] cursor_col_o
);

  logic       in_txn, out_txn;
  logic [1:0] pend_q, pend_d;

  assign in_txn  = in_valid_i && !in_stall_o;
  assign out_txn = out_valid_o && !out_stall_i;

  // items taken whose result is not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_txn && !out_txn) begin
      pend_d = pend_q + 2'd1;
    end else if (out_txn && !in_txn) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_txn |-> pend_q != 2'd0)
    else $error("result without an outstanding item");

  a_two_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |-> pend_q <= 2'd1)
    else $error("item taken with two results outstanding");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |=> in_stall_o)
    else $error("second item taken in back-to-back cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_row_o) < MaxRows) && (32'(cursor_col_o) < MaxCols))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker #(
  .MaxCols(MaxCols),
  .MaxRows(MaxRows)
) u_tcw_checker (.*);

FILE: verif/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for text_console_writer_unit: screen store and cursor mirrored in a
// scoreboard class, directed opcodes and control codes, then random text across screen sizes
// depends on tcw_pkg and the text_console_writer_unit rtl

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SCREEN_CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 50;
  // every item scrolling or clearing a full screen plus both sides idling
  localparam int LIMIT_CYCLES = 10_000_000;

  class screen_scoreboard;
    logic [CELL_W-1:0]     cells [SCREEN_CELLS];
    logic [COL_W-1:0]      cols_reg;
    logic [ROW_W-1:0]      rows_reg;
    logic [COLOR_W-1:0]    color_reg;
    int                    cursor_r;
    int                    cursor_c;
    result_t               due_results [$];
    int                    errors;

    function new();
      cols_reg  = RESET_COLS;
      rows_reg  = RESET_ROWS;
      color_reg = RESET_COLOR;
      foreach (cells[i]) cells[i] = RESET_CELL;
      cursor_r = 0;
      cursor_c = 0;
      errors   = 0;
    endfunction

    function int used_cols();
      if (cols_reg < 1) return 1;
      if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
      return int'(cols_reg);
    endfunction

    function int used_rows();
      if (rows_reg < 1) return 1;
      if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return int'(rows_reg);
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {color_reg, CH_SPACE};
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COLS:  cols_reg  = data[COL_W-1:0];
        CFG_ROWS:  rows_reg  = data[ROW_W-1:0];
        CFG_COLOR: color_reg = data;
        default: ;
      endcase
    endfunction

    // used rows move up within the used columns, bottom used row goes blank
    function void scroll_up(int rows, int cols);
      int r;
      int c;
      for (r = 1; r < rows; r++)
        for (c = 0; c < cols; c++)
          cells[(r - 1) * MAX_COLS_DEF + c] = cells[r * MAX_COLS_DEF + c];
      for (c = 0; c < cols; c++)
        cells[(rows - 1) * MAX_COLS_DEF + c] = blank_cell();
      cursor_r = rows - 1;
    endfunction

    function void new_line(int rows, int cols);
      cursor_c = 0;
      cursor_r++;
      if (cursor_r >= rows) scroll_up(rows, cols);
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch, int rows, int cols);
      case (ch)
        CH_NUL: ;
        CH_BS: begin
          if (cursor_c == 0) begin
            cursor_c = cols - 1;
            if (cursor_r != 0) cursor_r--;
          end else begin
            cursor_c--;
          end
          cells[cursor_r * MAX_COLS_DEF + cursor_c] = blank_cell();
        end
        CH_CR: cursor_c = 0;
        CH_LF: new_line(rows, cols);
        default: begin
          cells[cursor_r * MAX_COLS_DEF + cursor_c] = {color_reg, ch};
          cursor_c++;
          if (cursor_c >= cols) new_line(rows, cols);
        end
      endcase
    endfunction

    function void take_command(op_e op, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] tr,
                               logic [COL_W-1:0] tc);
      int      rows;
      int      cols;
      int      r;
      int      c;
      result_t res;
      rows = used_rows();
      cols = used_cols();
      res.cell_val = '0;
      // size may have shrunk under the cursor
      if (cursor_r >= rows) cursor_r = rows - 1;
      if (cursor_c >= cols) cursor_c = cols - 1;
      case (op)
        OP_PUT: put_char(ch, rows, cols);
        OP_MOVE: begin
          cursor_r = (tr < rows) ? int'(tr) : rows - 1;
          cursor_c = (tc < cols) ? int'(tc) : cols - 1;
        end
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = blank_cell();
          cursor_r = 0;
          cursor_c = 0;
        end
        default: begin
          r = (tr < rows) ? int'(tr) : rows - 1;
          c = (tc < cols) ? int'(tc) : cols - 1;
          res.cell_val = cells[r * MAX_COLS_DEF + c];
        end
      endcase
      res.row = cursor_r[ROW_W-1:0];
      res.col = cursor_c[COL_W-1:0];
      due_results.push_back(res);
    endfunction

    function void check_result(logic [CELL_W-1:0] cell_v, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: cell %h row %0d col %0d",
                 $time, cell_v, row, col);
        return;
      end
      want = due_results.pop_front();
      if (cell_v !== want.cell_val) begin
        errors++;
        $display("%0t: cell_value mismatch: expected %h actual %h", $time, want.cell_val,
                 cell_v);
      end
      if (row !== want.row) begin
        errors++;
        $display("%0t: cursor_row mismatch: expected %0d actual %0d", $time, want.row, row);
      end
      if (col !== want.col) begin
        errors++;
        $display("%0t: cursor_col mismatch: expected %0d actual %0d", $time, want.col, col);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_COLS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       opcode_i = OP_PUT;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [ROW_W-1:0]      target_row_i = '0;
  logic [COL_W-1:0]      target_col_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CELL_W-1:0]     cell_value_o;
  logic [ROW_W-1:0]      cursor_row_o;
  logic [COL_W-1:0]      cursor_col_o;

  screen_scoreboard board;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  int unsigned       stall_left = 0;
  int                items_sent = 0;
  int                cycle_count = 0;

  text_console_writer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  always #5 clk_i = ~clk_i;

  // result side: check each transaction, then hold stall for a random count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result(cell_value_o, cursor_row_o, cursor_col_o);
        stall_left = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(op_e op, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] tr,
                           logic [COL_W-1:0] tc);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    target_row_i <= tr;
    target_col_i <= tc;
    do @(posedge clk_i); while (in_stall_o);
    board.take_command(op, ch, tr, tc);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, data);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] cols_d, logic [CFG_DATA_W-1:0] rows_d,
                              logic [CFG_DATA_W-1:0] color_d, bit touch_spare);
    write_reg(CFG_COLS, cols_d);
    write_reg(CFG_ROWS, rows_d);
    write_reg(CFG_COLOR, color_d);
    if (touch_spare) write_reg(CFG_SPARE, 8'hA5);
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until every result is back, so the block is idle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(OP_READ, CH_NUL, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd31, 7'd127);
    send_item(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_item(OP_PUT, CH_NUL, 5'd0, 7'd0);
    send_item(OP_PUT, 8'hFF, 5'd31, 7'd127);
    send_item(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_item(OP_PUT, CH_CR, 5'd0, 7'd0);
    // backspace at column 0 of the top row wraps to the last column only
    send_item(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_item(OP_MOVE, CH_NUL, 5'd31, 7'd127);
    // wrap past the bottom right cell scrolls the screen
    send_item(OP_PUT, 8'h5A, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd23, 7'd79);
    send_item(OP_MOVE, CH_NUL, 5'd5, 7'd0);
    send_item(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_item(OP_PUT, CH_LF, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd4, 7'd79);
    send_item(OP_MOVE, CH_NUL, 5'd24, 7'd3);
    send_item(OP_PUT, CH_LF, 5'd0, 7'd0);
    send_item(OP_CLEAR, CH_NUL, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd24, 7'd79);
    send_item(OP_MOVE, CH_NUL, 5'd24, 7'd79);
    wait_drained();
    // zero sizes clamp to one cell, cursor clamps in on the next command
    set_geometry(8'h00, 8'h00, 8'hFF, 1'b1);
    send_item(OP_READ, CH_NUL, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h71, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd31, 7'd127);
    send_item(OP_PUT, CH_BS, 5'd0, 7'd0);
    wait_drained();
    set_geometry(8'hFF, 8'hFF, 8'h00, 1'b0);
    send_item(OP_PUT, 8'h7E, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 5'd0, 7'd0);
  endtask

  task automatic random_item(int rows, int cols);
    int               pick;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  tr;
    logic [COL_W-1:0]  tc;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      tr = ROW_W'($urandom_range(0, rows - 1));
      tc = COL_W'($urandom_range(0, cols - 1));
    end else begin
      tr = ROW_W'($urandom_range(0, 31));
      tc = COL_W'($urandom_range(0, 127));
    end
    if (pick < 50) begin
      ch = ($urandom_range(0, 4) == 0) ? CHAR_W'($urandom_range(128, 255))
                                       : CHAR_W'($urandom_range(32, 126));
      send_item(OP_PUT, ch, tr, tc);
    end else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0:       ch = CH_NUL;
        1:       ch = CH_BS;
        2:       ch = CH_CR;
        default: ch = CH_LF;
      endcase
      send_item(OP_PUT, ch, tr, tc);
    end else if (pick < 63) begin
      send_item(OP_PUT, CHAR_W'($urandom_range(0, 255)), tr, tc);
    end else if (pick < 71) begin
      send_item(OP_MOVE, CHAR_W'($urandom_range(0, 255)), tr, tc);
    end else if (pick < 97) begin
      send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), tr, tc);
    end else begin
      send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), tr, tc);
    end
  endtask

  task automatic run_random_phase();
    int               kind;
    int               count;
    logic [CFG_DATA_W-1:0] cols_d;
    logic [CFG_DATA_W-1:0] rows_d;
    kind = $urandom_range(0, 9);
    // upper data bits above the register width are random and must be dropped
    case (kind)
      0: begin
        cols_d = {1'($urandom_range(0, 1)), 7'($urandom_range(80, 127))};
        rows_d = {3'($urandom_range(0, 7)), 5'($urandom_range(25, 31))};
      end
      1: begin
        cols_d = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 1))};
        rows_d = {3'($urandom_range(0, 7)), 5'($urandom_range(0, 1))};
      end
      2: begin
        cols_d = CFG_DATA_W'($urandom_range(0, 255));
        rows_d = {3'($urandom_range(0, 7)), 5'($urandom_range(1, 3))};
      end
      default: begin
        cols_d = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 12))};
        rows_d = {3'($urandom_range(0, 7)), 5'($urandom_range(1, 6))};
      end
    endcase
    wait_drained();
    set_geometry(cols_d, rows_d, CFG_DATA_W'($urandom_range(0, 255)), 1'b0);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    count = (kind == 0) ? $urandom_range(15, 30) : $urandom_range(30, 80);
    repeat (count) begin
      random_item(board.used_rows(), board.used_cols());
      items_sent++;
    end
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset
    do @(posedge clk_i); while (in_stall_o);
    run_directed();
    while (items_sent < RANDOM_ITEMS) run_random_phase();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_out_stage.sv
sv/tcw_ctrl.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
verif/text_console_writer_unit_tb.sv
